/* rtl/b64d_pkg.sv */
// Shared types and constants for the base64 stream decoder.
// No dependencies; every other file in rtl/ imports this package.
package b64d_pkg;

    // Input actions.
    localparam logic [1:0] ACT_CHAR   = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;

    // Error codes reported on the result port.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_END        = 3'd1;
    localparam logic [2:0] ERR_PADDING    = 3'd2;
    localparam logic [2:0] ERR_ILLEGAL    = 3'd3;
    localparam logic [2:0] ERR_AFTER_PAD  = 3'd4;

    // One input beat.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
    } b64d_in_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic [2:0] error_code;
        logic       last_of_run;
    } b64d_out_t;

    // All results caused by one input beat, passed from the front end
    // to the output serializer. A run is either one error or 1..3 bytes.
    typedef struct packed {
        logic [1:0] count;
        logic       is_err;
        logic [2:0] err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } b64d_run_t;

endpackage

/* rtl/b64d_front.sv */
// Front end of the base64 decoder: classifies each character, keeps the
// digit phase, the accumulator and the sticky error flag, and forms runs.
// Depends on b64d_pkg.
module b64d_front
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  b64d_in_t  item,
    output logic      run_push,
    output b64d_run_t run
);

    // Phase codes: digits collected, one pad seen, stream closed.
    localparam logic [2:0] PH_D0     = 3'd0;
    localparam logic [2:0] PH_D1     = 3'd1;
    localparam logic [2:0] PH_D2     = 3'd2;
    localparam logic [2:0] PH_D3     = 3'd3;
    localparam logic [2:0] PH_PAD1   = 3'd4;
    localparam logic [2:0] PH_CLOSED = 3'd5;

    // Character classes beyond the 64 digit values.
    localparam logic [6:0] DIGIT_WS  = 7'd64;
    localparam logic [6:0] DIGIT_BAD = 7'd65;

    localparam logic [7:0] CH_PAD = 8'h3d;

    // Map a character code to its digit value or class.
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [6:0] d;
        if (c >= 8'h41 && c <= 8'h5a)
            d = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7a)
            d = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            d = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2b)
            d = 7'd62;
        else if (c == 8'h2f)
            d = 7'd63;
        else if (c == 8'd9 || c == 8'd10 || c == 8'd12 || c == 8'd13 || c == 8'd32)
            d = DIGIT_WS;
        else
            d = DIGIT_BAD;
        return d;
    endfunction

    logic [2:0]  phase_reg, phase_next;
    logic [23:0] acc_reg, acc_next;
    logic        failed_reg, failed_next;

    logic [6:0]  digit;
    logic [23:0] acc_shift;
    logic        do_pad;

    assign digit     = digit_of(item.char_code);
    assign acc_shift = {acc_reg[17:0], digit[5:0]};

    // Decode one beat into the next state and the run it causes.
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        failed_next = failed_reg;
        run         = '0;
        do_pad      = 1'b0;

        if (item.action == ACT_START)
        begin
            phase_next  = PH_D0;
            acc_next    = '0;
            failed_next = 1'b0;
        end
        else if (item.action == ACT_FINISH && !failed_reg)
        begin
            do_pad = (phase_reg == PH_D1) || (phase_reg == PH_D2) || (phase_reg == PH_D3);
        end
        else if (item.action == ACT_CHAR && !failed_reg)
        begin
            if (item.char_code == CH_PAD)
                do_pad = 1'b1;
            else if (digit == DIGIT_BAD)
            begin
                run.count   = 2'd1;
                run.is_err  = 1'b1;
                run.err     = ERR_ILLEGAL;
                failed_next = 1'b1;
            end
            else if (digit != DIGIT_WS)
            begin
                if (phase_reg > PH_D3)
                begin
                    run.count   = 2'd1;
                    run.is_err  = 1'b1;
                    run.err     = ERR_AFTER_PAD;
                    failed_next = 1'b1;
                end
                else if (phase_reg == PH_D3)
                begin
                    // Fourth digit releases three bytes.
                    run.count  = 2'd3;
                    run.b0     = acc_shift[23:16];
                    run.b1     = acc_shift[15:8];
                    run.b2     = acc_shift[7:0];
                    phase_next = PH_D0;
                    acc_next   = '0;
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                    acc_next   = acc_shift;
                end
            end
        end

        // Explicit or implicit padding.
        if (do_pad)
        begin
            unique case (phase_reg)
                PH_D3:
                begin
                    run.count  = 2'd2;
                    run.b0     = acc_reg[17:10];
                    run.b1     = acc_reg[9:2];
                    phase_next = PH_CLOSED;
                end
                PH_PAD1:
                begin
                    phase_next = PH_CLOSED;
                end
                PH_D2:
                begin
                    run.count  = 2'd1;
                    run.b0     = acc_reg[11:4];
                    phase_next = PH_PAD1;
                end
                PH_D1:
                begin
                    run.count   = 2'd1;
                    run.is_err  = 1'b1;
                    run.err     = ERR_END;
                    failed_next = 1'b1;
                end
                default:
                begin
                    run.count   = 2'd1;
                    run.is_err  = 1'b1;
                    run.err     = ERR_PADDING;
                    failed_next = 1'b1;
                end
            endcase
        end
    end

    assign run_push = fire && (run.count != 2'd0);

    // Decoder state advances on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_D0;
            acc_reg    <= '0;
            failed_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            failed_reg <= failed_next;
        end
    end

endmodule

/* rtl/b64d_queue.sv */
// Small run queue between the decoder front end and the output serializer.
// Depends on b64d_pkg.
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  b64d_run_t wr_data,
    output logic      q_full,
    input  logic      rd_en,
    output b64d_run_t rd_data,
    output logic      q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_run_t        slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = slots_reg[rd_ptr_reg];

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* rtl/b64d_back.sv */
// Output serializer: holds one run and hands out its results one beat at
// a time on the pop/empty port. Depends on b64d_pkg.
module b64d_back
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  b64d_run_t q_data,
    input  logic      q_empty,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output b64d_out_t result
);

    b64d_run_t  hold_reg;
    logic       hold_valid_reg;
    logic [1:0] idx_reg;

    logic       last;
    logic       take;
    logic [7:0] sel_byte;

    assign last  = (idx_reg == hold_reg.count - 2'd1);
    assign take  = !hold_valid_reg || (pop && last);
    assign q_pop = take && !q_empty;
    assign empty = !hold_valid_reg;

    // Pick the byte of the run that is due.
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = hold_reg.b0;
            2'd1:    sel_byte = hold_reg.b1;
            default: sel_byte = hold_reg.b2;
        endcase
    end

    assign result.data_byte   = hold_reg.is_err ? 8'd0 : sel_byte;
    assign result.byte_valid  = !hold_reg.is_err;
    assign result.error_code  = hold_reg.is_err ? hold_reg.err : ERR_NONE;
    assign result.last_of_run = last;

    // Run holding register and result index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (take)
        begin
            hold_valid_reg <= !q_empty;
            idx_reg        <= '0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            hold_reg <= q_data;
    end

endmodule

/* rtl/base64_stream_decoder.sv */
// Base64 stream decoder top level: front end, run queue and output serializer.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Takes one character (or a finish or start action) per clock cycle whenever
// full is low. Each beat causes zero to three result beats, held as one run in
// a queue of QUEUE_DEPTH runs; the serializer hands out one result beat per
// cycle while pop is high, so input rate is one character per cycle and output
// rate is one result per cycle when neither side stalls. Input stalls only when
// the queue of runs is full, which happens when results are produced faster
// than one per cycle over time or when pop is held low. When the path is clear,
// the first result of an accepted character is written into the queue, then
// loaded into the serializer's hold register, from which it can be popped.
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  b64d_in_t  item,
    output logic      empty,
    input  logic      pop,
    output b64d_out_t result
);

    logic      fire;
    logic      run_push;
    b64d_run_t run;
    b64d_run_t q_data;
    logic      q_empty;
    logic      q_pop;

    assign fire = push && !full;

    // Character classification and decoder state.
    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item),
        .run_push (run_push),
        .run      (run)
    );

    // Decouples the front end from the result port.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (run_push),
        .wr_data (run),
        .q_full  (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    // One result beat per cycle while pop is high and a result is held.
    b64d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
